[design/mjsl_pkg.sv]
// shared types and constants for the multi-joint slew limiter
`timescale 1ns / 1ps

package mjsl_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned JOINT_W = 2;
  localparam int unsigned FRAME_W = 3;
  localparam int unsigned FCNT_W  = 4;
  localparam int unsigned MAX_JOINTS = 4;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SNAP   = 2'd2;
  localparam logic [1:0] CMD_FREEZE = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_STEP_PITCH    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SHOULDER = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_ELBOW    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP_GRIP     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_MIN     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_MAX     = 3'd5;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    logic                      run;
    logic [JOINT_W-1:0]        joint;
    logic [FCNT_W-1:0]         frame;
    logic                      joint_end;
    logic                      last;
  } seq_ctl_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] value;
    logic                      moving;
    logic                      jump;
  } step_res_t;

endpackage

[design/mjsl_step_unit.sv]
// shared step unit: one frame of motion for one joint
`timescale 1ns / 1ps

module mjsl_step_unit (
  input  logic signed [mjsl_pkg::ANGLE_W-1:0] cur,
  input  logic signed [mjsl_pkg::ANGLE_W-1:0] tgt,
  input  logic        [mjsl_pkg::STEP_W-1:0]  step,
  output mjsl_pkg::step_res_t                 res
);
  import mjsl_pkg::*;

  logic signed [ANGLE_W:0] cur_x;
  logic signed [ANGLE_W:0] tgt_x;
  logic signed [ANGLE_W:0] step_x;
  logic signed [ANGLE_W:0] up_val;
  logic signed [ANGLE_W:0] dn_val;
  logic                    go_up;
  logic                    go_dn;

  assign cur_x  = {cur[ANGLE_W-1], cur};
  assign tgt_x  = {tgt[ANGLE_W-1], tgt};
  assign step_x = {2'b00, step};
  assign up_val = cur_x + step_x;
  assign dn_val = cur_x - step_x;
  assign go_up  = tgt_x > up_val;
  assign go_dn  = tgt_x < dn_val;

  always_comb begin
    res.jump   = (step == '0);
    res.moving = 1'b0;
    res.value  = tgt;
    if (!res.jump) begin
      priority if (go_up) begin
        res.value  = up_val[ANGLE_W-1:0];
        res.moving = 1'b1;
      end else if (go_dn) begin
        res.value  = dn_val[ANGLE_W-1:0];
        res.moving = 1'b1;
      end else begin
        res.value  = tgt;
      end
    end
  end

endmodule

[design/mjsl_seq.sv]
// sequencer walking joints and frames of one tick
`timescale 1ns / 1ps

module mjsl_seq #(
  parameter int unsigned NUM_FRAMES = 4,
  parameter int unsigned NUM_JOINTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               adv,
  input  logic               jump,
  output mjsl_pkg::seq_ctl_t ctl
);
  import mjsl_pkg::*;

  localparam logic [JOINT_W-1:0] LAST_JOINT = JOINT_W'(NUM_JOINTS - 1);
  localparam logic [FCNT_W-1:0]  LAST_FRAME = FCNT_W'(NUM_FRAMES - 1);

  seq_state_t           state_r, state_nxt;
  logic [JOINT_W-1:0]   joint_r, joint_nxt;
  logic [FCNT_W-1:0]    frame_r, frame_nxt;
  logic                 joint_end;
  logic                 last;

  assign joint_end = jump || (frame_r == LAST_FRAME);
  assign last      = joint_end && (joint_r == LAST_JOINT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_RUN;
      ST_RUN:  if (adv && last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    joint_nxt = joint_r;
    frame_nxt = frame_r;
    unique case (state_r)
      ST_IDLE: begin
        joint_nxt = '0;
        frame_nxt = '0;
      end
      ST_RUN: begin
        if (adv) begin
          if (joint_end) begin
            joint_nxt = joint_r + 1'b1;
            frame_nxt = '0;
          end else begin
            frame_nxt = frame_r + 1'b1;
          end
        end
      end
      default: begin
        joint_nxt = '0;
        frame_nxt = '0;
      end
    endcase
  end

  always_comb begin
    ctl.run       = (state_r == ST_RUN);
    ctl.joint     = joint_r;
    ctl.frame     = frame_r;
    ctl.joint_end = joint_end;
    ctl.last      = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      joint_r <= '0;
      frame_r <= '0;
    end else begin
      state_r <= state_nxt;
      joint_r <= joint_nxt;
      frame_r <= frame_nxt;
    end
  end

endmodule

[design/multi_joint_slew_limiter.sv]
// top level of the multi-joint slew limiter
`timescale 1ns / 1ps

// Slew-rate limiter for up to four arm joints, Q3.12 angles.
// Input channel in_*: in_tuser carries the command (set targets, tick,
// snapshot, freeze), in_tdata the four joint values. Set, snapshot and
// freeze take effect in the cycle they are accepted and give no result.
// A tick while dirty walks joints 0..NUM_JOINTS-1 in order: a joint with a
// zero step gives one result (frame = NUM_FRAMES), any other gives
// NUM_FRAMES results. One result a cycle comes from the shared step unit
// while the receiver does not stall, and each result passes through the
// output register; the input is not ready while a tick is in progress.
// Output channel out_*: out_tuser holds joint and frame, out_tdata the
// command, out_tlast marks the final result of the tick. A stalled
// receiver holds the sequencer; the result waits in the output register.
// cfg_* writes a register per cycle with no wait; write only when idle.
// Reset clears all joints to zero, steps to zero, the clip range to full
// scale and sets the dirty flag; no clearing pass is needed.
module multi_joint_slew_limiter #(
  parameter int unsigned NUM_FRAMES = 4,
  parameter int unsigned NUM_JOINTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [63:0]                       in_tdata,   // value_pitch, value_shoulder, value_elbow, value_grip
  input  logic [1:0]                        in_tuser,   // cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // command
  output logic [4:0]                        out_tuser,  // joint, frame
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [mjsl_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [15:0]                       cfg_wdata
);
  import mjsl_pkg::*;

  logic        [STEP_W-1:0]  step_r [MAX_JOINTS];
  logic signed [ANGLE_W-1:0] amin_r;
  logic signed [ANGLE_W-1:0] amax_r;
  logic signed [ANGLE_W-1:0] cur_r  [MAX_JOINTS];
  logic signed [ANGLE_W-1:0] tgt_r  [MAX_JOINTS];
  logic                      dirty_r;

  logic                      out_valid_r;
  logic [ANGLE_W-1:0]        out_cmd_r;
  logic [JOINT_W-1:0]        out_joint_r;
  logic [FRAME_W-1:0]        out_frame_r;
  logic                      out_last_r;

  logic signed [ANGLE_W-1:0] in_val [MAX_JOINTS];
  logic signed [ANGLE_W-1:0] clip_val [MAX_JOINTS];
  logic                      in_acc;
  logic [1:0]                cmd;
  logic                      start;
  logic                      adv;
  logic                      emit;
  seq_ctl_t                  ctl;
  step_res_t                 res;
  logic [FRAME_W-1:0]        frame_out;

  assign cmd       = in_tuser;
  assign in_tready = !ctl.run;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (cmd == CMD_TICK) && dirty_r;
  assign adv       = !out_valid_r || out_tready;
  assign emit      = ctl.run && adv;

  always_comb begin
    for (int j = 0; j < MAX_JOINTS; j++) begin
      in_val[j]   = in_tdata[j*ANGLE_W +: ANGLE_W];
      clip_val[j] = in_val[j];
      if (clip_val[j] < amin_r) clip_val[j] = amin_r;
      if (clip_val[j] > amax_r) clip_val[j] = amax_r;
    end
  end

  mjsl_seq #(
    .NUM_FRAMES(NUM_FRAMES),
    .NUM_JOINTS(NUM_JOINTS)
  ) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .adv  (adv),
    .jump (res.jump),
    .ctl  (ctl)
  );

  mjsl_step_unit u_step (
    .cur (cur_r[ctl.joint]),
    .tgt (tgt_r[ctl.joint]),
    .step(step_r[ctl.joint]),
    .res (res)
  );

  assign frame_out = res.jump ? FRAME_W'(NUM_FRAMES) : ctl.frame[FRAME_W-1:0];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_JOINTS; j++) step_r[j] <= '0;
      amin_r <= 16'sh8000;
      amax_r <= 16'sh7fff;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STEP_PITCH:    step_r[0] <= cfg_wdata[STEP_W-1:0];
        REG_STEP_SHOULDER: step_r[1] <= cfg_wdata[STEP_W-1:0];
        REG_STEP_ELBOW:    step_r[2] <= cfg_wdata[STEP_W-1:0];
        REG_STEP_GRIP:     step_r[3] <= cfg_wdata[STEP_W-1:0];
        REG_ANGLE_MIN:     amin_r    <= cfg_wdata;
        REG_ANGLE_MAX:     amax_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // joint state and dirty flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_JOINTS; j++) begin
        cur_r[j] <= '0;
        tgt_r[j] <= '0;
      end
      dirty_r <= 1'b1;
    end else if (in_acc) begin
      unique case (cmd)
        CMD_SET: begin
          for (int j = 0; j < MAX_JOINTS; j++)
            if (j < NUM_JOINTS) tgt_r[j] <= clip_val[j];
          dirty_r <= 1'b1;
        end
        CMD_SNAP: begin
          for (int j = 0; j < MAX_JOINTS; j++)
            if (j < NUM_JOINTS) begin
              tgt_r[j] <= in_val[j];
              cur_r[j] <= in_val[j];
            end
          dirty_r <= 1'b1;
        end
        CMD_FREEZE: begin
          for (int j = 0; j < MAX_JOINTS; j++)
            if (j < NUM_JOINTS) tgt_r[j] <= cur_r[j];
          dirty_r <= 1'b0;
        end
        CMD_TICK: begin
          if (dirty_r) dirty_r <= 1'b0;
        end
        default: ;
      endcase
    end else if (emit) begin
      cur_r[ctl.joint] <= res.value;
      // still moving on the final frame keeps the block dirty
      if (ctl.joint_end && res.moving) dirty_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl.run;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cmd_r   <= res.value;
      out_joint_r <= ctl.joint;
      out_frame_r <= frame_out;
      out_last_r  <= ctl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_cmd_r;
  assign out_tuser  = {out_frame_r, out_joint_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] <= JOINT_W'(NUM_JOINTS - 1)))
    else $error("result for a joint beyond the arm");

  a_clean_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_TICK) && !dirty_r) |=> in_tready)
    else $error("tick while clean started a run");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(in_tready)) |-> (out_tvalid && out_tlast))
    else $error("run ended without a final item");

  a_run_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !dirty_r || ctl.run)
    else $error("dirty flag not cleared at tick start");
`endif

endmodule

[bench/multi_joint_slew_limiter_test.sv]
// testbench for the multi-joint slew limiter: directed table then random phases against a motion predictor
`timescale 1ns / 1ps

module multi_joint_slew_limiter_test;
  import mjsl_pkg::*;

  localparam int FRAMES = 4;
  localparam int JOINTS = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_PER_PHASE = 42;
  localparam int RAND_PHASES = 6;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [1:0]         joint;
    logic [2:0]         frame;
    logic signed [15:0] command;
    logic               last;
  } arm_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // code is the command for an item row and the register index for a write row
  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         code;
    logic signed [15:0] v0;
    logic signed [15:0] v1;
    logic signed [15:0] v2;
    logic signed [15:0] v3;
    logic               pinned;
    logic signed [15:0] w0;
    logic signed [15:0] w1;
    logic signed [15:0] w2;
    logic signed [15:0] w3;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // value_pitch, value_shoulder, value_elbow, value_grip
  logic [1:0]  in_tuser = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // command
  logic [4:0]  out_tuser;       // joint, frame
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // predictor copy of the arm
  int arm_cur [JOINTS];
  int arm_tgt [JOINTS];
  bit arm_dirty = 1'b1;
  int step_lim [JOINTS];
  int clip_lo = -32768;
  int clip_hi = 32767;

  arm_result_t arm_results [$];
  arm_result_t seen;
  arm_result_t want;
  int errors = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  stim_row_t dir_tab [33] = '{
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   1, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_SET,    32767, -32768, 4660, -1,      0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   1, 32767, -32768, 4660, -1},
    '{ROW_ITEM, CMD_SNAP,   -32768, 32767, 100, -100,     0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   1, -32768, 32767, 100, -100},
    '{ROW_ITEM, CMD_FREEZE, 0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_STEP_PITCH,    1000, 0, 0, 0,         0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_STEP_SHOULDER, 32767, 0, 0, 0,        0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_STEP_ELBOW,    1, 0, 0, 0,            0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_ANGLE_MIN,     -16384, 0, 0, 0,       0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_ANGLE_MAX,     16384, 0, 0, 0,        0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_SET,    32767, -32768, -32768, 20000, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_FREEZE, 0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_ANGLE_MIN,     100, 0, 0, 0,          0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_ANGLE_MAX,     -100, 0, 0, 0,         0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_SET,    1234, -5000, 32767, -32768,   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_STEP_GRIP,     32767, 0, 0, 0,        0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_ANGLE_MIN,     -32768, 0, 0, 0,       0, 0, 0, 0, 0},
    '{ROW_CFG,  REG_ANGLE_MAX,     32767, 0, 0, 0,        0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_SNAP,   32767, -32768, 32767, -32768, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_SET,    -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_SET,    5, -5, 0, 32767,              0, 0, 0, 0, 0},
    '{ROW_ITEM, CMD_TICK,   0, 0, 0, 0,                   0, 0, 0, 0, 0}
  };

  multi_joint_slew_limiter #(
    .NUM_FRAMES(FRAMES),
    .NUM_JOINTS(JOINTS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic arm_result_t make_result(input int j, input int f, input int val);
    arm_result_t r;
    r.joint = 2'(j);
    r.frame = 3'(f);
    r.command = 16'(val);
    r.last = 1'b0;
    return r;
  endfunction

  // update the arm for one accepted item; keep selects whether results are queued
  task automatic advance_arm(input logic [1:0] cmd, input logic [63:0] data, input bit keep);
    arm_result_t batch [$];
    int j;
    int v;
    int stp;
    int tgt;
    int f;
    case (cmd)
      CMD_SET: begin
        for (j = 0; j < JOINTS; j++) begin
          v = $signed(data[16*j +: 16]);
          if (v < clip_lo) v = clip_lo;
          if (v > clip_hi) v = clip_hi;
          arm_tgt[j] = v;
        end
        arm_dirty = 1'b1;
      end
      CMD_SNAP: begin
        for (j = 0; j < JOINTS; j++) begin
          arm_tgt[j] = $signed(data[16*j +: 16]);
          arm_cur[j] = arm_tgt[j];
        end
        arm_dirty = 1'b1;
      end
      CMD_FREEZE: begin
        for (j = 0; j < JOINTS; j++) arm_tgt[j] = arm_cur[j];
        arm_dirty = 1'b0;
      end
      default: begin
        if (arm_dirty) begin
          arm_dirty = 1'b0;
          for (j = 0; j < JOINTS; j++) begin
            stp = step_lim[j];
            tgt = arm_tgt[j];
            f = 0;
            if (stp == 0) begin
              arm_cur[j] = tgt;
              batch.push_back(make_result(j, FRAMES, tgt));
            end else begin
              while (tgt > arm_cur[j] + stp && f < FRAMES) begin
                arm_cur[j] += stp;
                batch.push_back(make_result(j, f, arm_cur[j]));
                f++;
              end
              while (tgt < arm_cur[j] - stp && f < FRAMES) begin
                arm_cur[j] -= stp;
                batch.push_back(make_result(j, f, arm_cur[j]));
                f++;
              end
              if (f < FRAMES) begin
                arm_cur[j] = tgt;
                while (f < FRAMES) begin
                  batch.push_back(make_result(j, f, tgt));
                  f++;
                end
              end else begin
                arm_dirty = 1'b1;
              end
            end
          end
        end
      end
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    if (keep) foreach (batch[i]) arm_results.push_back(batch[i]);
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [63:0] data, input bit keep);
    @(negedge clk);
    if (tx_idle_on && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_arm(cmd, data, keep);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (arm_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ANGLE_MIN: clip_lo = $signed(val);
      REG_ANGLE_MAX: clip_hi = $signed(val);
      default:       step_lim[idx[1:0]] = int'(val[14:0]);
    endcase
  endtask

  function automatic logic [15:0] pick_angle(input int base);
    int r;
    int v;
    r = $urandom_range(19);
    if (r < 3) begin
      v = $urandom_range(1) ? 32767 : -32768;
    end else if (r < 8) begin
      v = int'($urandom_range(65535)) - 32768;
    end else begin
      // mostly near the current target so that joints arrive
      v = base + int'($urandom_range(6000)) - 3000;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end
    return 16'(v);
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd32767;
      3:       return 16'($urandom_range(64, 1));
      4:       return 16'($urandom_range(2000, 1));
      default: return 16'($urandom_range(32767));
    endcase
  endfunction

  task automatic send_random(input logic [1:0] cmd, inout int counted);
    logic [63:0] data;
    int j;
    for (j = 0; j < JOINTS; j++) data[16*j +: 16] = pick_angle(arm_tgt[j]);
    counted++;
    send_item(cmd, data, 1'b1);
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (rx_idle_on && $urandom_range(99) < 14) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.joint = out_tuser[1:0];
      seen.frame = out_tuser[4:2];
      seen.command = out_tdata;
      seen.last = out_tlast;
      if (arm_results.size() == 0) begin
        report_error($sformatf("unexpected item joint %0d frame %0d command %0d",
                               seen.joint, seen.frame, seen.command));
      end else begin
        want = arm_results.pop_front();
        if (seen.joint !== want.joint)
          report_error($sformatf("joint %0d, wanted %0d", seen.joint, want.joint));
        if (seen.frame !== want.frame)
          report_error($sformatf("frame %0d, wanted %0d", seen.frame, want.frame));
        if (seen.command !== want.command)
          report_error($sformatf("joint %0d frame %0d command %0d, wanted %0d",
                                 want.joint, want.frame, seen.command, want.command));
        if (seen.last !== want.last)
          report_error($sformatf("last %0b, wanted %0b", seen.last, want.last));
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [63:0] data;
    logic [15:0] a;
    logic [15:0] b;
    bit after_items;
    int counted;
    int ph;
    int k;
    int r;
    for (k = 0; k < JOINTS; k++) begin
      arm_cur[k] = 0;
      arm_tgt[k] = 0;
      step_lim[k] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    after_items = 1'b0;
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) begin
        if (after_items) wait_idle();
        after_items = 1'b0;
        write_reg(row.code, row.v0);
      end else begin
        after_items = 1'b1;
        data = {row.v3, row.v2, row.v1, row.v0};
        send_item(row.code[1:0], data, !row.pinned);
        if (row.pinned) begin
          arm_results.push_back(make_result(0, FRAMES, row.w0));
          arm_results.push_back(make_result(1, FRAMES, row.w1));
          arm_results.push_back(make_result(2, FRAMES, row.w2));
          arm_results.push_back({make_result(3, FRAMES, row.w3)} | 22'd1);
        end
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      // no idling at all in one phase
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 3);
      for (k = 0; k < JOINTS; k++) begin
        if (ph == 0) write_reg(REG_STEP_PITCH + 3'(k), 16'd1);
        else if (ph == RAND_PHASES - 1) write_reg(REG_STEP_PITCH + 3'(k), 16'd32767);
        else write_reg(REG_STEP_PITCH + 3'(k), pick_step());
      end
      a = 16'($urandom);
      b = 16'($urandom);
      r = (ph == 0 || ph == RAND_PHASES - 1) ? 0 : $urandom_range(3);
      case (r)
        0: begin
          write_reg(REG_ANGLE_MIN, 16'h8000);
          write_reg(REG_ANGLE_MAX, 16'h7fff);
        end
        1: begin
          write_reg(REG_ANGLE_MIN, ($signed(a) < $signed(b)) ? a : b);
          write_reg(REG_ANGLE_MAX, ($signed(a) < $signed(b)) ? b : a);
        end
        2: begin
          // inverted range
          write_reg(REG_ANGLE_MIN, ($signed(a) < $signed(b)) ? b : a);
          write_reg(REG_ANGLE_MAX, ($signed(a) < $signed(b)) ? a : b);
        end
        default: begin
          write_reg(REG_ANGLE_MIN, a);
          write_reg(REG_ANGLE_MAX, a);
        end
      endcase
      if (ph == 1) begin
        // long receiver hold-off while items keep coming
        @(posedge clk);
        rx_hold = 400;
      end
      counted = 0;
      while (counted < RAND_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 50) begin
          send_random(CMD_SET, counted);
          repeat ($urandom_range(4)) send_random(CMD_TICK, counted);
        end else if (r < 70) begin
          send_random(CMD_SNAP, counted);
          repeat ($urandom_range(4)) send_random(CMD_TICK, counted);
        end else if (r < 82) begin
          send_random(CMD_FREEZE, counted);
        end else begin
          send_random(CMD_TICK, counted);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
